[rtl/core/sss_pkg.sv]
// shared types and constants for the sorted store search core
package sss_pkg;
	localparam int CAPACITY = 1024;
	localparam int VAL_W = 32;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = IDX_W + 1;

	localparam logic [1:0] REQ_CLEAR = 2'd0;
	localparam logic [1:0] REQ_INSERT = 2'd1;
	localparam logic [1:0] REQ_QUERY = 2'd2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam logic [1:0] ST_MISS = 2'd0;
	localparam logic [1:0] ST_HIT = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic signed [VAL_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [CNT_W-1:0] position;
		logic signed [VAL_W-1:0] echo_value;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic clr;
		logic probe_rd;
		logic probe_cmp;
		logic hit_rd;
		logic shift_rd;
		logic shift_wr;
		logic put;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic search_done;
		logic shift_more;
		logic full;
		logic empty;
		logic out_free;
		logic is_insert;
	} sts_t;
endpackage

[rtl/core/sss_dp.sv]
// datapath: value memory, search bounds, shift pointer and result register
module sss_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  sss_pkg::cmd_t     cmd,
	output sss_pkg::sts_t     sts,
	input  sss_pkg::in_item_t in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output sss_pkg::out_item_t out_item
);
	import sss_pkg::*;

	logic signed [VAL_W-1:0] mem [CAPACITY];
	logic signed [VAL_W-1:0] rdata_q;
	logic [1:0] req_q;
	logic signed [VAL_W-1:0] val_q;
	logic [CNT_W-1:0] count_q, lo_q, hi_q, mid_q, ptr_q, mid_w, ptr_m1;
	logic [IDX_W-1:0] raddr;
	logic go_right, hit, out_valid_q;
	out_item_t out_q;

	assign mid_w = lo_q + ((hi_q - lo_q) >> 1);
	assign ptr_m1 = ptr_q - CNT_W'(1);
	assign go_right = (req_q == REQ_INSERT) ? (rdata_q <= val_q) : (rdata_q < val_q);
	assign hit = (lo_q < count_q) && (rdata_q == val_q);

	always_comb begin
		raddr = lo_q[IDX_W-1:0];
		if (cmd.probe_rd) begin
			raddr = mid_w[IDX_W-1:0];
		end else if (cmd.shift_rd) begin
			raddr = ptr_m1[IDX_W-1:0];
		end
	end

	// single write port, single registered read port
	always_ff @(posedge clk) begin
		if (cmd.shift_wr) begin
			mem[ptr_q[IDX_W-1:0]] <= rdata_q;
		end else if (cmd.put) begin
			mem[lo_q[IDX_W-1:0]] <= val_q;
		end
		if (cmd.probe_rd || cmd.shift_rd || cmd.hit_rd) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_valid_q <= 1'b0;
			req_q <= REQ_CLEAR;
		end else begin
			if (cmd.clr) begin
				count_q <= '0;
			end else if (cmd.put) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.load) begin
				req_q <= in_item.req_type;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= in_item.value;
			lo_q <= '0;
			hi_q <= count_q;
			ptr_q <= count_q;
		end
		if (cmd.probe_rd) begin
			mid_q <= mid_w;
		end
		if (cmd.probe_cmp) begin
			if (go_right) begin
				lo_q <= mid_q + CNT_W'(1);
			end else begin
				hi_q <= mid_q;
			end
		end
		if (cmd.shift_wr) begin
			ptr_q <= ptr_m1;
		end
		if (cmd.emit) begin
			out_q.echo_value <= val_q;
			if (req_q == REQ_INSERT) begin
				out_q.status <= ST_FULL;
				out_q.position <= '0;
			end else begin
				out_q.status <= hit ? ST_HIT : ST_MISS;
				out_q.position <= hit ? lo_q + CNT_W'(1) : '0;
			end
		end
	end

	assign sts.search_done = (lo_q >= hi_q);
	assign sts.shift_more = (ptr_q > lo_q);
	assign sts.full = (count_q >= CNT_W'(CAPACITY));
	assign sts.empty = (count_q == '0);
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.is_insert = (req_q == REQ_INSERT);
	assign out_valid = out_valid_q;
	assign out_item = out_q;
endmodule

[rtl/core/sss_ctrl.sv]
// controller state machine sequencing search, shift and result
module sss_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [1:0]    req_type,
	output logic          in_ready,
	input  sss_pkg::sts_t sts,
	output sss_pkg::cmd_t cmd
);
	import sss_pkg::*;

	typedef enum logic [2:0] {
		IDLE, PROBE_RD, PROBE_CMP, HIT_RD, SHIFT_RD, SHIFT_WR, PUT, EMIT
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					unique case (req_type)
						REQ_CLEAR: cmd.clr = 1'b1;
						REQ_INSERT: state_d = sts.full ? EMIT : PROBE_RD;
						REQ_QUERY: state_d = PROBE_RD;
						default: state_d = IDLE;
					endcase
				end
			end
			PROBE_RD: begin
				if (sts.search_done) begin
					state_d = sts.is_insert ? SHIFT_RD : HIT_RD;
				end else begin
					cmd.probe_rd = 1'b1;
					state_d = PROBE_CMP;
				end
			end
			PROBE_CMP: begin
				cmd.probe_cmp = 1'b1;
				state_d = PROBE_RD;
			end
			HIT_RD: begin
				cmd.hit_rd = 1'b1;
				state_d = EMIT;
			end
			SHIFT_RD: begin
				if (sts.shift_more) begin
					cmd.shift_rd = 1'b1;
					state_d = SHIFT_WR;
				end else begin
					state_d = PUT;
				end
			end
			SHIFT_WR: begin
				cmd.shift_wr = 1'b1;
				state_d = SHIFT_RD;
			end
			PUT: begin
				cmd.put = 1'b1;
				state_d = IDLE;
			end
			EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = IDLE;
				end
			end
			default: state_d = IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

[rtl/core/sorted_store_first_match_search_core.sv]
// top level of the sorted store with leftmost binary search
// query: each probe is a ram read then a compare; then a read of the found slot
// insert: same search, then a read and a write per entry moved up, then the put
// clear and unused codes: no result; full insert: straight to the result
// throughput: one item at a time, the next is taken once the controller is back in idle
// arst_n clears the entry count, controller state and result valid; the ram holds no reset
module sorted_store_first_match_search_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sss_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output sss_pkg::out_item_t  out_item
);
	import sss_pkg::*;

	// command and status between controller and datapath
	cmd_t cmd;
	sts_t sts;

	// controller walks search, shift and result steps one at a time
	sss_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.req_type(in_item.req_type),
		.in_ready(in_ready),
		.sts(sts),
		.cmd(cmd)
	);

	// datapath holds the ascending value ram and the result register
	sss_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	// a clear item empties the store by the next edge
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_item.req_type == REQ_CLEAR |=> sts.empty)
		else $error("store not empty after clear");

	// a query always leaves idle to search
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_item.req_type == REQ_QUERY |=> !in_ready)
		else $error("query not taken up");

	// a result is only raised when the register was free
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result overwritten");

	// entry count never passes capacity
	a_no_put_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put |-> !sts.full)
		else $error("insert into full store");
endmodule

[bench/testbench.sv]
// self-checking testbench for the sorted store search core
`timescale 1ns / 1ps

module testbench;
	import sss_pkg::*;

	// expected results and a private copy of the sorted store
	class search_scoreboard;
		logic signed [VAL_W-1:0] held[$];
		out_item_t pending[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		// work out what one accepted item should produce
		function void note_item(in_item_t it);
			out_item_t r;
			int slot;
			slot = 0;
			case (it.req_type)
				REQ_CLEAR: held.delete();
				REQ_INSERT: begin
					if (held.size() >= CAPACITY) begin
						r.status = ST_FULL;
						r.position = '0;
						r.echo_value = it.value;
						pending = {pending, r};
					end else begin
						// after any equal values
						while (slot < held.size() && held[slot] <= it.value)
							slot++;
						held.insert(slot, it.value);
					end
				end
				REQ_QUERY: begin
					while (slot < held.size() && held[slot] < it.value)
						slot++;
					r.echo_value = it.value;
					if (slot < held.size() && held[slot] == it.value) begin
						r.status = ST_HIT;
						r.position = CNT_W'(slot + 1);
					end else begin
						r.status = ST_MISS;
						r.position = '0;
					end
					pending = {pending, r};
				end
				default: ;
			endcase
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
				errors++;
			end
			if (got.position !== want.position) begin
				$display("%0t: position expected %0d actual %0d", $time,
					want.position, got.position);
				errors++;
			end
			if (got.echo_value !== want.echo_value) begin
				$display("%0t: echo expected %0d actual %0d", $time,
					want.echo_value, got.echo_value);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_item;
	logic out_valid;
	logic out_ready;
	out_item_t out_item;

	search_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_off;

	sorted_store_first_match_search_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// offer one item, with a random gap first, and hold it until taken
	task automatic send_item(logic [1:0] kind, logic signed [VAL_W-1:0] v);
		in_item_t it;
		it.req_type = kind;
		it.value = v;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_item(it);
	endtask

	// mostly small values so that duplicates and hits are common
	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return $urandom;
			1: return {1'b1, {(VAL_W-1){1'b0}}};
			2: return {1'b0, {(VAL_W-1){1'b1}}};
			default: return $signed($urandom_range(40)) - 20;
		endcase
	endfunction

	// receiver: random stalls, plus a long hold-off when asked
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result(out_item);
			out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		int i;
		int burst;
		int n;
		sb = new();
		in_valid = 1'b0;
		in_item = '0;
		arst_n = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty store, extremes, duplicates, unused code
		send_item(REQ_QUERY, 0);
		send_item(REQ_INSERT, {1'b0, {(VAL_W-1){1'b1}}});
		send_item(REQ_INSERT, {1'b1, {(VAL_W-1){1'b0}}});
		send_item(REQ_INSERT, 5);
		send_item(REQ_INSERT, 5);
		send_item(REQ_INSERT, -1);
		send_item(REQ_INSERT, 0);
		send_item(REQ_QUERY, 5);
		send_item(REQ_QUERY, {1'b1, {(VAL_W-1){1'b0}}});
		send_item(REQ_QUERY, {1'b0, {(VAL_W-1){1'b1}}});
		send_item(REQ_QUERY, -1);
		send_item(REQ_QUERY, 4);
		send_item(REQ_UNUSED, 5);
		send_item(REQ_QUERY, 6);
		send_item(REQ_CLEAR, -1);
		send_item(REQ_QUERY, 5);
		send_item(REQ_QUERY, 32'h5555_aaaa);
		send_item(REQ_QUERY, 32'haaaa_5555);

		// fill the store to capacity, then overflow it
		send_item(REQ_CLEAR, 0);
		for (i = 0; i < CAPACITY; i++)
			send_item(REQ_INSERT, $signed($urandom_range(600)) - 300);
		send_item(REQ_INSERT, 7);
		send_item(REQ_INSERT, $urandom);
		send_item(REQ_QUERY, -300);
		send_item(REQ_QUERY, 300);

		// long receiver hold-off while queries keep coming
		hold_off = 1'b1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			begin
				for (i = 0; i < 20; i++)
					send_item(REQ_QUERY, $signed($urandom_range(600)) - 300);
				in_valid <= 1'b0;
			end
		join
		@(posedge clk);
		send_item(REQ_CLEAR, 0);

		// random sequences across the idling phases
		n = 0;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 62; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 62; end
				default: begin send_idle_pct = 14; recv_stall_pct = 14; end
			endcase
			while (n < 40 * (ph + 1)) begin
				burst = $urandom_range(10);
				for (i = 0; i < burst; i++)
					send_item(REQ_INSERT, pick_value());
				for (i = 0; i < burst; i++)
					send_item(REQ_QUERY, pick_value());
				n += 2 * burst;
				case ($urandom_range(9))
					0: send_item(REQ_CLEAR, $urandom);
					1: send_item(REQ_UNUSED, $urandom);
					default: ;
				endcase
				n++;
			end
		end
		in_valid <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// generous bound: full store inserts move each entry up with a read and a write
	initial begin
		#20000000;
		$display("FAILURE");
		$finish;
	end
endmodule
